/* hdl/spmq_pkg.sv */
// Shared types and constants for the shared-pool multi-queue block.
// Used by spmq_pool and shared_pool_multi_queue; depends on nothing else.
`default_nettype none

package spmq_pkg;

    // Default sizes of the pool and of the queue set.
    localparam int SLOTS_DEF  = 16;
    localparam int QUEUES_DEF = 4;

    // Fixed field widths.
    localparam int DATA_W  = 32;
    localparam int QID_W   = 2;
    localparam int STAT_W  = 2;

    // Operation codes carried in the kind field.
    localparam logic KIND_ENQ = 1'b0;
    localparam logic KIND_DEQ = 1'b1;

    // Result status codes.
    typedef enum logic [STAT_W-1:0] {
        STAT_DONE  = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    // Control of the slot pool for one cycle.
    typedef struct packed {
        logic rd_en;    // capture read data at the addressed slot
        logic link_we;  // write the link entry at the addressed slot
        logic data_we;  // write the data word at the addressed slot
    } pool_ctl_t;

endpackage

`default_nettype wire

/* hdl/shared_pool_multi_queue.sv */
// Top level of the shared-pool multi-queue: sequencer, queue pointers, free list.
// Depends on spmq_pkg and instantiates spmq_pool.
//
// Usage: QUEUES FIFO queues share a pool of SLOTS words. A request transfer
// (req_valid, req_stall) carries kind, queue_id and data_in; kind selects an
// enqueue of data_in or a dequeue. Each request gives exactly one response
// transfer (rsp_valid, rsp_stall) with data_out and status: done, pool full
// on enqueue, or queue empty on dequeue. A queue number not below QUEUES is
// treated as full on enqueue and empty on dequeue and changes nothing.
// The request is registered; the calculation state reads the link table and
// the write-back state updates it and loads the response. A request is taken
// only in idle or as the last one completes, set by the single link table port.
// Reset leaves every queue empty and all slots on the free list; no clearing
// pass runs, so requests are taken from the first cycle after reset.
// When the receiver stalls, a finished response is held in the output
// register; one further request is taken and its update waits in the
// write-back state until the output register is free.
`default_nettype none

module shared_pool_multi_queue #(
    parameter int SLOTS  = spmq_pkg::SLOTS_DEF,
    parameter int QUEUES = spmq_pkg::QUEUES_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 req_valid,
    output logic                                      req_stall,
    input  wire logic                                 kind,
    input  wire logic        [spmq_pkg::QID_W-1:0]    queue_id,
    input  wire logic signed [spmq_pkg::DATA_W-1:0]   data_in,
    output logic                                      rsp_valid,
    input  wire logic                                 rsp_stall,
    output logic signed      [spmq_pkg::DATA_W-1:0]   data_out,
    output logic             [spmq_pkg::STAT_W-1:0]   status
);

    localparam int PW = $clog2(SLOTS + 1);
    localparam logic [PW-1:0] NIL = PW'(SLOTS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_WB
    } state_t;

    state_t                              state_reg, state_next;
    logic                                kind_reg, kind_next;
    logic [spmq_pkg::QID_W-1:0]          qid_reg, qid_next;
    logic [spmq_pkg::DATA_W-1:0]         word_reg, word_next;

    logic [PW-1:0]                       head_reg [QUEUES];
    logic [PW-1:0]                       head_next [QUEUES];
    logic [PW-1:0]                       tail_reg [QUEUES];
    logic [PW-1:0]                       tail_next [QUEUES];
    logic [PW-1:0]                       free_head_reg, free_head_next;

    logic                                rsp_valid_reg, rsp_valid_next;
    logic [spmq_pkg::DATA_W-1:0]         rsp_data_reg, rsp_data_next;
    spmq_pkg::status_t                   rsp_status_reg, rsp_status_next;

    logic                                q_exists;
    logic [PW-1:0]                       cur_head;
    logic [PW-1:0]                       cur_tail;
    logic                                head_valid;
    logic                                tail_valid;
    logic                                enq_ok;
    logic                                deq_ok;
    logic                                out_free;
    logic [PW-1:0]                       next_ptr;

    spmq_pkg::pool_ctl_t                 pool_ctl;
    logic [PW-1:0]                       pool_addr;
    logic [PW-1:0]                       pool_link_wd;
    logic [PW-1:0]                       pool_link_rd;
    logic [spmq_pkg::DATA_W-1:0]         pool_data_rd;

    spmq_pool #(
        .SLOTS (SLOTS)
    ) u_pool (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (pool_ctl),
        .addr    (pool_addr),
        .link_wd (pool_link_wd),
        .data_wd (word_reg),
        .link_rd (pool_link_rd),
        .data_rd (pool_data_rd)
    );

    // Pointers of the addressed queue; head and tail do not change between
    // the calculation and write-back states, so both states decode the same request.
    always_comb
    begin
        q_exists = 1'b0;
        cur_head = NIL;
        cur_tail = NIL;
        for (int q = 0; q < QUEUES; q++)
        begin
            if (q == int'(qid_reg))
            begin
                q_exists = 1'b1;
                cur_head = head_reg[q];
                cur_tail = tail_reg[q];
            end
        end
    end

    assign head_valid = (cur_head < NIL);
    assign tail_valid = (cur_tail < NIL);
    assign enq_ok     = (kind_reg == spmq_pkg::KIND_ENQ) && q_exists && (free_head_reg < NIL);
    assign deq_ok     = (kind_reg == spmq_pkg::KIND_DEQ) && q_exists && head_valid;
    assign next_ptr   = (pool_link_rd < NIL) ? pool_link_rd : NIL;
    assign out_free   = !rsp_valid_reg || !rsp_stall;

    assign req_stall  = !((state_reg == S_IDLE) || ((state_reg == S_WB) && out_free));

    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        qid_next        = qid_reg;
        word_next       = word_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        free_head_next  = free_head_reg;
        rsp_data_next   = rsp_data_reg;
        rsp_status_next = rsp_status_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;

        pool_ctl        = '0;
        pool_addr       = cur_tail;
        pool_link_wd    = free_head_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    kind_next  = kind;
                    qid_next   = queue_id;
                    word_next  = data_in;
                    state_next = S_CALC;
                end
            end

            S_CALC:
            begin
                // Read and rewrite the link of the chosen slot in one access:
                // the old link comes back while the new one is written.
                pool_ctl.rd_en = 1'b1;
                if (kind_reg == spmq_pkg::KIND_ENQ)
                begin
                    pool_addr        = free_head_reg;
                    pool_link_wd     = NIL;
                    pool_ctl.link_we = enq_ok;
                    pool_ctl.data_we = enq_ok;
                end
                else
                begin
                    pool_addr        = cur_head;
                    pool_link_wd     = free_head_reg;
                    pool_ctl.link_we = deq_ok;
                end
                state_next = S_WB;
            end

            S_WB:
            begin
                if (out_free)
                begin
                    // Chain the new slot behind the old tail of a non-empty queue.
                    pool_addr        = cur_tail;
                    pool_link_wd     = free_head_reg;
                    pool_ctl.link_we = enq_ok && head_valid && tail_valid;

                    if (enq_ok)
                    begin
                        free_head_next = next_ptr;
                    end
                    if (deq_ok)
                    begin
                        free_head_next = cur_head;
                    end
                    for (int q = 0; q < QUEUES; q++)
                    begin
                        if (q == int'(qid_reg))
                        begin
                            if (enq_ok)
                            begin
                                if (!head_valid)
                                begin
                                    head_next[q] = free_head_reg;
                                end
                                tail_next[q] = free_head_reg;
                            end
                            if (deq_ok)
                            begin
                                head_next[q] = next_ptr;
                            end
                        end
                    end

                    rsp_valid_next = 1'b1;
                    rsp_data_next  = deq_ok ? pool_data_rd : '0;
                    if (enq_ok || deq_ok)
                    begin
                        rsp_status_next = spmq_pkg::STAT_DONE;
                    end
                    else if (kind_reg == spmq_pkg::KIND_ENQ)
                    begin
                        rsp_status_next = spmq_pkg::STAT_FULL;
                    end
                    else
                    begin
                        rsp_status_next = spmq_pkg::STAT_EMPTY;
                    end

                    if (req_valid)
                    begin
                        kind_next  = kind;
                        qid_next   = queue_id;
                        word_next  = data_in;
                        state_next = S_CALC;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            free_head_reg <= '0;
            rsp_valid_reg <= 1'b0;
            for (int q = 0; q < QUEUES; q++)
            begin
                head_reg[q] <= NIL;
                tail_reg[q] <= NIL;
            end
        end
        else
        begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            rsp_valid_reg <= rsp_valid_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        qid_reg        <= qid_next;
        word_reg       <= word_next;
        rsp_data_reg   <= rsp_data_next;
        rsp_status_reg <= rsp_status_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign data_out  = rsp_data_reg;
    assign status    = rsp_status_reg;

    // The free list head is either a real slot or the null marker.
    a_free_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        free_head_reg <= NIL)
        else $error("free list head beyond null marker");

    // Requests are only taken when idle or as the previous one completes.
    a_accept_state: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |-> (state_reg == S_IDLE || state_reg == S_WB))
        else $error("request taken in the middle of an operation");

    // The update cycle waits while the output register is still occupied.
    a_wb_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WB && !out_free) |=> (state_reg == S_WB))
        else $error("update cycle left while the response was stalled");

    // A successful dequeue is reported as done.
    a_deq_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WB && out_free && deq_ok)
        |=> (rsp_valid_reg && rsp_status_reg == spmq_pkg::STAT_DONE))
        else $error("successful dequeue not reported as done");

endmodule

`default_nettype wire

/* hdl/spmq_pool.sv */
// Slot pool: link table and data store, one port each, with registered reads.
// Depends on spmq_pkg for the control struct and default sizes.
`default_nettype none

module spmq_pool #(
    parameter int SLOTS = spmq_pkg::SLOTS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire spmq_pkg::pool_ctl_t           ctl,
    input  wire logic [$clog2(SLOTS+1)-1:0]    addr,
    input  wire logic [$clog2(SLOTS+1)-1:0]    link_wd,
    input  wire logic [spmq_pkg::DATA_W-1:0]   data_wd,
    output logic      [$clog2(SLOTS+1)-1:0]    link_rd,
    output logic      [spmq_pkg::DATA_W-1:0]   data_rd
);

    localparam int PW = $clog2(SLOTS + 1);
    localparam int SW = $clog2(SLOTS);

    logic [PW-1:0]               link_mem [SLOTS];
    logic [spmq_pkg::DATA_W-1:0] data_mem [SLOTS];

    logic [SW-1:0]               idx;
    logic [PW-1:0]               link_q_reg;
    logic [spmq_pkg::DATA_W-1:0] data_q_reg;

    // Slots at or above the fill mark have never had their link written, so a
    // read of one returns the reset chain value of its own index plus one.
    logic [PW-1:0]               fill_reg;
    logic [PW-1:0]               fill_next;
    logic [PW-1:0]               rd_addr_reg;
    logic                        rd_fresh_reg;

    assign idx = addr[SW-1:0];

    always_ff @(posedge clk)
    begin
        if (ctl.link_we)
        begin
            link_mem[idx] <= link_wd;
        end
        if (ctl.rd_en)
        begin
            link_q_reg <= link_mem[idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.data_we)
        begin
            data_mem[idx] <= data_wd;
        end
        if (ctl.rd_en)
        begin
            data_q_reg <= data_mem[idx];
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (ctl.link_we && (addr == fill_reg))
        begin
            fill_next = fill_reg + PW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= '0;
            rd_fresh_reg <= 1'b0;
            rd_addr_reg  <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (ctl.rd_en)
            begin
                rd_fresh_reg <= (addr >= fill_reg);
                rd_addr_reg  <= addr;
            end
        end
    end

    assign link_rd = rd_fresh_reg ? (rd_addr_reg + PW'(1)) : link_q_reg;
    assign data_rd = data_q_reg;

endmodule

`default_nettype wire
